>>> rtl/kal_pkg.sv
// Package for the scalar Kalman update block: field widths, fixed-point
// constants, the beat types of both channels and the control state type.
// No dependencies.
`default_nettype none

package kal_pkg;

    // Field widths. These settle the widths of the beat fields.
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_FRAC = 16;
    localparam int GAIN_W    = GAIN_FRAC + 1;
    localparam int VAR_W     = 32;

    // One point zero in Q1.GAIN_FRAC.
    localparam logic [GAIN_W-1:0] GAIN_ONE   = {1'b1, {GAIN_FRAC{1'b0}}};
    // Predicted variance after reset: one point zero in Q16.16.
    localparam logic [VAR_W-1:0]  PVAR_RESET = {{(VAR_W-17){1'b0}}, 1'b1, 16'h0000};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [VAR_W-1:0]           meas_variance;
        logic [VAR_W-1:0]           proc_variance;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] estimate;
        logic [GAIN_W-1:0]          gain;
        logic [VAR_W-1:0]           est_variance;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

>>> rtl/kal_div.sv
// Restoring divider for the Kalman gain, one quotient bit per cycle.
// Depends on kal_pkg for the variance and gain widths.
`default_nettype none

module kal_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [kal_pkg::VAR_W-1:0]     i_num,
    input  wire [kal_pkg::VAR_W:0]       i_den,
    output logic [kal_pkg::GAIN_W-1:0]   o_quo,
    output logic                         o_done
);
    import kal_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);

    logic             r_busy;
    logic             r_first;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAR_W:0]   r_rem;
    logic [VAR_W:0]   r_den;
    logic [GAIN_W-1:0] r_quo;

    logic [VAR_W+1:0] w_trial;
    logic [VAR_W+1:0] w_diff;
    logic             w_ge;

    // The numerator never exceeds the denominator, so the first step takes
    // the remainder as it is and every later step doubles it.
    always_comb begin
        w_trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_first <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_cnt   <= CNT_W'(GAIN_W - 1);
            end else if (r_busy) begin
                r_first <= 1'b0;
                r_cnt   <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VAR_W:0] : w_trial[VAR_W:0];
            r_quo <= {r_quo[GAIN_W-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> rtl/kal_mul.sv
// Shift-and-add multiplier that consumes one multiplier bit per cycle,
// least significant first. Depends on kal_pkg only through the import.
`default_nettype none

module kal_mul #(
    parameter int A_W = 32,
    parameter int B_W = 17
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [A_W-1:0]        i_a,
    input  wire [B_W-1:0]        i_b,
    output logic [A_W+B_W-1:0]   o_prod,
    output logic                 o_done
);
    import kal_pkg::*;

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_hi;
    logic [B_W-1:0]   r_lo;
    logic [A_W:0]     w_add;

    // The low register holds the unused multiplier bits and collects the
    // low product bits as they drop out of the accumulator.
    assign w_add = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= w_add[A_W:1];
            r_lo <= {w_add[0], r_lo[B_W-1:1]};
        end
    end

    assign o_prod = {r_hi, r_lo};
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> rtl/scalar_kalman_update.sv
// An accepted input beat runs through the 17-step serial divider for the gain, then
// the two 17-step serial multipliers, then a final step that waits for room in the
// output register, and the block takes no new beat until it is back in idle;
// a new beat is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) clears the estimate to zero and sets the
// predicted variance to one point zero.
`default_nettype none

module scalar_kalman_update (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire kal_pkg::t_in_beat i_in_beat,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output kal_pkg::t_out_beat  o_out_beat
);
    import kal_pkg::*;

    localparam int PA_W = VAR_W + GAIN_W;
    localparam int PB_W = SAMPLE_W + 1 + GAIN_W;
    localparam int EW   = SAMPLE_W + 2;

    // Clamp limits of the estimate, held at the width of the raw update sum.
    localparam logic signed [EW-1:0] EST_HI = EW'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [EW-1:0] EST_LO = ~EST_HI;
    localparam logic [PB_W:0]        RND_HALF = (PB_W + 1)'(1) << (GAIN_FRAC - 1);

    // Filter state.
    t_state                     r_state;
    t_state                     n_state;
    logic signed [SAMPLE_W-1:0] r_pest;
    logic [VAR_W-1:0]           r_pvar;

    // Per-beat working registers.
    logic                       r_zero;
    logic                       r_neg;
    logic [SAMPLE_W:0]          r_mag;
    logic [VAR_W-1:0]           r_q;
    logic [GAIN_W-1:0]          r_gain;
    logic [VAR_W-1:0]           r_var;
    logic [VAR_W-1:0]           r_nvar;
    logic [SAMPLE_W:0]          r_corr;

    // Output register.
    logic                       r_out_valid;
    t_out_beat                  r_out_beat;

    logic                       w_in_fire;
    logic                       w_fin_load;
    logic                       w_out_free;
    logic [VAR_W:0]             w_sum;
    logic signed [SAMPLE_W:0]   w_diff;
    logic [SAMPLE_W:0]          w_mag;
    logic [GAIN_W-1:0]          w_gain;
    logic [GAIN_W-1:0]          w_one_minus;
    logic                       w_div_done;
    logic [GAIN_W-1:0]          w_div_quo;
    logic                       w_mul_done;
    logic                       w_mulb_done;
    logic [PA_W-1:0]            w_prod_a;
    logic [PB_W-1:0]            w_prod_b;
    logic [PB_W:0]              w_rounded;
    logic [VAR_W:0]             w_nvar;
    logic signed [EW-1:0]       w_corr_ext;
    logic signed [EW-1:0]       w_corr_s;
    logic signed [EW-1:0]       w_est_sum;
    logic signed [SAMPLE_W-1:0] w_est;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Front end: the gain denominator Vp + R at 33 bits so it never wraps,
    // and the innovation z - x split into sign and magnitude for the
    // unsigned serial multiplier.
    always_comb begin
        w_sum  = {1'b0, r_pvar} + {1'b0, i_in_beat.meas_variance};
        w_diff = $signed({i_in_beat.sample[SAMPLE_W-1], i_in_beat.sample})
               - $signed({r_pest[SAMPLE_W-1], r_pest});
        w_mag  = w_diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-w_diff) : w_diff;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_zero <= (w_sum == '0);
            r_neg  <= w_diff[SAMPLE_W];
            r_mag  <= w_mag;
            r_q    <= i_in_beat.proc_variance;
        end
    end

    // The gain is Vp * 2^GAIN_FRAC / (Vp + R). Since R is never negative the
    // quotient never exceeds one. A zero denominator gives a gain of zero.
    kal_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_fire),
        .i_num   (r_pvar),
        .i_den   (w_sum),
        .o_quo   (w_div_quo),
        .o_done  (w_div_done)
    );

    assign w_gain      = r_zero ? '0 : w_div_quo;
    assign w_one_minus = GAIN_ONE - w_gain;

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_gain <= w_gain;
        end
    end

    // (1 - G) * Vp for the updated variance.
    kal_mul #(
        .A_W (VAR_W),
        .B_W (GAIN_W)
    ) u_mul_var (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_done),
        .i_a     (r_pvar),
        .i_b     (w_one_minus),
        .o_prod  (w_prod_a),
        .o_done  (w_mul_done)
    );

    // G * |z - x| for the estimate correction.
    kal_mul #(
        .A_W (SAMPLE_W + 1),
        .B_W (GAIN_W)
    ) u_mul_est (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_done),
        .i_a     (r_mag),
        .i_b     (w_gain),
        .o_prod  (w_prod_b),
        .o_done  (w_mulb_done)
    );

    // Both multipliers start together and take the same number of steps.
    // The correction rounds half away from zero: it is rounded as a
    // magnitude and the sign is applied afterwards. The next predicted
    // variance saturates at full scale.
    always_comb begin
        w_rounded = {1'b0, w_prod_b} + RND_HALF;
        w_nvar    = {1'b0, w_prod_a[GAIN_FRAC +: VAR_W]} + {1'b0, r_q};
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_done && w_mulb_done) begin
            r_var  <= w_prod_a[GAIN_FRAC +: VAR_W];
            r_nvar <= w_nvar[VAR_W] ? {VAR_W{1'b1}} : w_nvar[VAR_W-1:0];
            r_corr <= w_rounded[GAIN_FRAC +: SAMPLE_W + 1];
        end
    end

    // The new estimate lies between x and z, but it is still clamped to the
    // sample range.
    always_comb begin
        w_corr_ext = $signed({1'b0, r_corr});
        w_corr_s   = r_neg ? -w_corr_ext : w_corr_ext;
        w_est_sum  = $signed({{2{r_pest[SAMPLE_W-1]}}, r_pest}) + w_corr_s;
        if (w_est_sum > EST_HI) begin
            w_est = EST_HI[SAMPLE_W-1:0];
        end else if (w_est_sum < EST_LO) begin
            w_est = EST_LO[SAMPLE_W-1:0];
        end else begin
            w_est = w_est_sum[SAMPLE_W-1:0];
        end
    end

    // Sequencer: idle, gain division, the two multiplies, then the final
    // step that waits for room in the output register.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_fin_load = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_FIN:  w_fin_load = w_out_free;
            default: begin
                o_in_ready = 1'b0;
                w_fin_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pest      <= '0;
            r_pvar      <= PVAR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin_load) begin
                r_pest      <= w_est;
                r_pvar      <= r_nvar;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_out_beat.estimate     <= w_est;
            r_out_beat.gain         <= r_gain;
            r_out_beat.est_variance <= r_var;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

`default_nettype wire

>>> rtl/kal_chk.sv
// Port-level checker for scalar_kalman_update, bound to the top level.
// Depends on kal_pkg for the beat types and the gain of one.
`default_nettype none

module kal_chk (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input wire kal_pkg::t_out_beat o_out_beat
);
    import kal_pkg::*;

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_beat))
        else $error("stalled result beat changed");

    // Once a beat is taken the block is busy with it.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after a beat");

    // The gain never exceeds one.
    a_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.gain <= GAIN_ONE))
        else $error("gain above one");

    // A gain of one leaves no variance.
    a_full_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.gain == GAIN_ONE)) |-> (o_out_beat.est_variance == '0))
        else $error("variance left after a gain of one");

endmodule

bind scalar_kalman_update kal_chk u_kal_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire
